/* src/fpa_pkg.sv */
// shared types and constants of the fixed-point alu
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int DATA_W        = 32;

    typedef enum logic [3:0] {
        FN_ADD     = 4'd0,
        FN_SUB     = 4'd1,
        FN_MUL     = 4'd2,
        FN_DIV     = 4'd3,
        FN_MAX     = 4'd4,
        FN_MIN     = 4'd5,
        FN_GT      = 4'd6,
        FN_LT      = 4'd7,
        FN_GE      = 4'd8,
        FN_LE      = 4'd9,
        FN_EQ      = 4'd10,
        FN_NE      = 4'd11,
        FN_INC     = 4'd12,
        FN_DEC     = 4'd13,
        FN_TOINT   = 4'd14,
        FN_FROMINT = 4'd15
    } func_t;

    // everything that rides alongside the divider state
    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              cmp;
        logic              dz;
        logic              is_div;
        logic              neg;
    } side_t;

endpackage

/* src/fpa_if.sv */
// valid/ready channel interfaces for operand and result beats
interface fpa_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         func;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, output func, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input func, input operand_a, input operand_b,
                    output ready);
endinterface

interface fpa_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic               compare_true;
    logic               divide_by_zero;

    modport source (output valid, output result, output compare_true,
                    output divide_by_zero, input ready);
    modport sink   (input valid, input result, input compare_true,
                    input divide_by_zero, output ready);
endinterface

/* src/fpa_front.sv */
// entry stage: decode, simple ops, multiply, divider operand set-up
module fpa_front #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    fpa_in_if.sink               operands,
    input  logic                 dn_ready,
    output logic                 dn_valid,
    output fpa_pkg::side_t       dn_side,
    output logic [FRAC_BITS+31:0] dn_quo,
    output logic [31:0]          dn_dvs
);
    import fpa_pkg::*;

    localparam int DIV_W = DATA_W + FRAC_BITS;

    func_t              fn;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [63:0] prod;
    logic [31:0]        abs_a;
    logic [31:0]        abs_b;
    side_t              side_next;
    logic               accept;
    logic               valid_reg;
    side_t              side_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [31:0]        dvs_reg;

    always_comb
    begin
        a         = operands.operand_a;
        b         = operands.operand_b;
        fn        = func_t'(operands.func);
        prod      = 64'(a) * 64'(b);
        abs_a     = a[31] ? 32'(-a) : a;
        abs_b     = b[31] ? 32'(-b) : b;
        side_next = '0;
        case (fn)
            FN_ADD:     side_next.result = a + b;
            FN_SUB:     side_next.result = a - b;
            FN_MUL:     side_next.result = 32'(prod >>> FRAC_BITS);
            FN_DIV:
            begin
                side_next.is_div = 1'b1;
                side_next.dz     = (b == 32'sd0);
            end
            FN_MAX:     side_next.result = (a > b) ? a : b;
            FN_MIN:     side_next.result = (a < b) ? a : b;
            FN_GT:      side_next.cmp = (a > b);
            FN_LT:      side_next.cmp = (a < b);
            FN_GE:      side_next.cmp = (a >= b);
            FN_LE:      side_next.cmp = (a <= b);
            FN_EQ:      side_next.cmp = (a == b);
            FN_NE:      side_next.cmp = (a != b);
            FN_INC:     side_next.result = a + 32'sd1;
            FN_DEC:     side_next.result = a - 32'sd1;
            FN_TOINT:   side_next.result = a >>> FRAC_BITS;
            FN_FROMINT: side_next.result = a <<< FRAC_BITS;
            default:    side_next = '0;
        endcase
        side_next.neg = a[31] ^ b[31];
    end

    assign operands.ready = !valid_reg || dn_ready;
    assign accept         = operands.valid && operands.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (operands.ready)
            valid_reg <= operands.valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            side_reg <= side_next;
            quo_reg  <= DIV_W'(abs_a) << FRAC_BITS;
            dvs_reg  <= abs_b;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_side  = side_reg;
    assign dn_quo   = quo_reg;
    assign dn_dvs   = dvs_reg;

endmodule

/* src/fpa_div_cell.sv */
// one restoring-division cell: one quotient bit per cell
module fpa_div_cell #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  fpa_pkg::side_t        up_side,
    input  logic [31:0]           up_rem,
    input  logic [FRAC_BITS+31:0] up_quo,
    input  logic [31:0]           up_dvs,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output fpa_pkg::side_t        dn_side,
    output logic [31:0]           dn_rem,
    output logic [FRAC_BITS+31:0] dn_quo,
    output logic [31:0]           dn_dvs
);
    import fpa_pkg::*;

    localparam int DIV_W = DATA_W + FRAC_BITS;

    logic [32:0]      trial;
    logic [32:0]      diff;
    logic             fits;
    logic [31:0]      rem_next;
    logic [DIV_W-1:0] quo_next;
    logic             valid_reg;
    side_t            side_reg;
    logic [31:0]      rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [31:0]      dvs_reg;

    // shift in the next dividend bit, subtract if the divisor fits
    always_comb
    begin
        trial    = {up_rem, up_quo[DIV_W-1]};
        diff     = trial - {1'b0, up_dvs};
        fits     = (trial >= {1'b0, up_dvs});
        rem_next = fits ? diff[31:0] : trial[31:0];
        quo_next = {up_quo[DIV_W-2:0], fits};
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            side_reg <= up_side;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvs_reg  <= up_dvs;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_side  = side_reg;
    assign dn_rem   = rem_reg;
    assign dn_quo   = quo_reg;
    assign dn_dvs   = dvs_reg;

endmodule

/* src/fpa_back.sv */
// output stage: quotient sign fix, result select, output register
module fpa_back #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  fpa_pkg::side_t        up_side,
    input  logic [FRAC_BITS+31:0] up_quo,
    fpa_out_if.source             results
);
    import fpa_pkg::*;

    logic [31:0] result_next;
    logic        valid_reg;
    logic [31:0] result_reg;
    logic        cmp_reg;
    logic        dz_reg;

    always_comb
    begin
        if (!up_side.is_div)
            result_next = up_side.result;
        else if (up_side.dz)
            result_next = '0;
        else if (up_side.neg)
            result_next = 32'(-up_quo[31:0]);
        else
            result_next = up_quo[31:0];
    end

    assign up_ready = !valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            result_reg <= result_next;
            cmp_reg    <= up_side.cmp;
            dz_reg     <= up_side.dz;
        end
    end

    assign results.valid          = valid_reg;
    assign results.result         = result_reg;
    assign results.compare_true   = cmp_reg;
    assign results.divide_by_zero = dz_reg;

endmodule

/* src/fixed_point_alu.sv */
// top level of the signed fixed-point alu
// Signed fixed-point ALU on 32-bit raw values with FRAC_BITS fraction bits
// (Q24.8 by default). One operand beat gives one result beat; a new beat can
// be taken every cycle while results are being taken, and results leave in
// the order they came in. Each operation passes through one entry stage, one
// cell of the division chain per quotient bit (32 + FRAC_BITS cells, one
// restoring step each) and one output register. Every operation goes down the
// same chain so the order is kept without a reorder buffer.
// Each stage has its own valid flag and gives way to the next stage, so
// empty slots close up while the output is stalled and operands are still
// taken until the chain is full. Results wrap to 32 bits; comparisons give
// a result of zero with compare_true holding the outcome; a divide by zero
// gives zero with divide_by_zero set. There is no configuration and no state
// beyond the pipeline.
module fixed_point_alu #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    fpa_in_if.sink     operands,
    fpa_out_if.source  results
);
    import fpa_pkg::*;

    // dividend width: operand magnitude scaled by the fraction bits
    localparam int DIV_W = DATA_W + FRAC_BITS;

    // stage 0 is the entry stage, stage i+1 is the output of cell i
    logic             stg_valid [0:DIV_W];
    logic             stg_ready [0:DIV_W];
    side_t            stg_side  [0:DIV_W];
    logic [31:0]      stg_rem   [0:DIV_W];
    logic [DIV_W-1:0] stg_quo   [0:DIV_W];
    logic [31:0]      stg_dvs   [0:DIV_W];

    // partial remainder starts at zero
    assign stg_rem[0] = '0;

    // decode, simple ops and multiply; magnitudes set up for the divider
    fpa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands),
        .dn_ready (stg_ready[0]),
        .dn_valid (stg_valid[0]),
        .dn_side  (stg_side[0]),
        .dn_quo   (stg_quo[0]),
        .dn_dvs   (stg_dvs[0])
    );

    // division chain, one quotient bit per cell
    for (genvar i = 0; i < DIV_W; i++)
    begin : g_cell
        fpa_div_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[i]),
            .up_ready (stg_ready[i]),
            .up_side  (stg_side[i]),
            .up_rem   (stg_rem[i]),
            .up_quo   (stg_quo[i]),
            .up_dvs   (stg_dvs[i]),
            .dn_valid (stg_valid[i+1]),
            .dn_ready (stg_ready[i+1]),
            .dn_side  (stg_side[i+1]),
            .dn_rem   (stg_rem[i+1]),
            .dn_quo   (stg_quo[i+1]),
            .dn_dvs   (stg_dvs[i+1])
        );
    end

    // sign correction of the quotient and the output register
    fpa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (stg_valid[DIV_W]),
        .up_ready (stg_ready[DIV_W]),
        .up_side  (stg_side[DIV_W]),
        .up_quo   (stg_quo[DIV_W]),
        .results  (results)
    );

`ifndef SYNTHESIS
    // a divide-by-zero beat carries a zero result and no compare outcome
    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.divide_by_zero
        |-> results.result == '0 && !results.compare_true)
    else $error("divide by zero beat with non-zero payload");

    // a comparison beat carries a zero result
    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.compare_true |-> results.result == '0)
    else $error("compare beat with non-zero result");

    // an empty output register never holds back the last cell
    a_back_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !results.valid |-> stg_ready[DIV_W])
    else $error("output stage stalls while empty");
`endif

endmodule

/* tb/fpa_result_checker.sv */
// result checker for the fixed-point alu: predicts every result beat and compares it
module fpa_result_checker #(
    parameter int FRAC = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    fpa_in_if    opnd,
    fpa_out_if   res,
    output int   fail_count,
    output int   n_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    import fpa_pkg::*;

    typedef struct packed {
        logic signed [31:0] result;
        logic               cmp;
        logic               dz;
    } alu_out_t;

    alu_out_t expected_results[$];
    int       n_fail = 0;
    int       n_left = 0;

    assign fail_count = n_fail;
    assign n_waiting  = n_left;

    function automatic alu_out_t compute_alu_result(func_t fn, logic signed [31:0] a,
                                                    logic signed [31:0] b);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] wide;
        alu_out_t           r;
        wa   = a;
        wb   = b;
        wide = '0;
        r    = '0;
        case (fn)
            FN_ADD:     r.result = a + b;
            FN_SUB:     r.result = a - b;
            FN_MUL:
            begin
                wide     = (wa * wb) >>> FRAC;
                r.result = wide[31:0];
            end
            FN_DIV:
            begin
                if (b == 0)
                begin
                    r.dz = 1'b1;
                end
                else
                begin
                    // 64-bit signed divide truncates toward zero
                    wide     = (wa <<< FRAC) / wb;
                    r.result = wide[31:0];
                end
            end
            FN_MAX:     r.result = (a > b) ? a : b;
            FN_MIN:     r.result = (a < b) ? a : b;
            FN_GT:      r.cmp = (a > b);
            FN_LT:      r.cmp = (a < b);
            FN_GE:      r.cmp = (a >= b);
            FN_LE:      r.cmp = (a <= b);
            FN_EQ:      r.cmp = (a == b);
            FN_NE:      r.cmp = (a != b);
            FN_INC:     r.result = a + 32'sd1;
            FN_DEC:     r.result = a - 32'sd1;
            FN_TOINT:   r.result = a >>> FRAC;
            FN_FROMINT: r.result = a <<< FRAC;
            default:    r = 'x;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        alu_out_t want;
        if (rst_n)
        begin
            if (opnd.valid && opnd.ready)
            begin
                expected_results.push_back(compute_alu_result(func_t'(opnd.func),
                                                              opnd.operand_a,
                                                              opnd.operand_b));
            end
            if (res.valid && res.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: result %h cmp %b dz %b",
                             $realtime, res.result, res.compare_true, res.divide_by_zero);
                    n_fail++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res.result !== want.result)
                    begin
                        $display("%0t: result mismatch: expected %h, got %h",
                                 $realtime, want.result, res.result);
                        n_fail++;
                    end
                    if (res.compare_true !== want.cmp)
                    begin
                        $display("%0t: compare_true mismatch: expected %b, got %b",
                                 $realtime, want.cmp, res.compare_true);
                        n_fail++;
                    end
                    if (res.divide_by_zero !== want.dz)
                    begin
                        $display("%0t: divide_by_zero mismatch: expected %b, got %b",
                                 $realtime, want.dz, res.divide_by_zero);
                        n_fail++;
                    end
                end
            end
            n_left = expected_results.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// top of the fixed-point alu testbench: clock, reset, operand and result traffic, verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fpa_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    // every operation runs down the full divider chain
    localparam int LATENCY     = FRAC + 34;
    localparam int N_RANDOM    = 600;
    // long result hold-off, long enough to fill the whole chain and stall the input
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 300;
    // beats in this window run with no idling on either side
    localparam int BURST_FIRST = 300;
    localparam int BURST_LAST  = 399;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    fpa_in_if  operands_bus ();
    fpa_out_if results_bus ();

    int fail_count;
    int n_waiting;
    int beats_in       = 0;
    int cycle_count    = 0;
    bit no_idle        = 1'b0;
    bit long_hold_done = 1'b0;

    fixed_point_alu #(
        .FRAC_BITS (FRAC)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands_bus),
        .results  (results_bus)
    );

    fpa_result_checker #(
        .FRAC (FRAC)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .opnd       (operands_bus),
        .res        (results_bus),
        .fail_count (fail_count),
        .n_waiting  (n_waiting)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // watchdog: a hung handshake or a lost result ends up here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL fixed_point_alu");
            $finish;
        end
    end

    // idle length: mostly none, often a short gap, now and then a long one
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // operand mix: corners, small magnitudes, single bits and full-range values
    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 11))
            0:       return 32'sd0;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh8000_0000;
            3:       return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
            4:       return $urandom_range(0, 8191) - 4096;
            5:       return 32'sd1 << $urandom_range(0, 31);
            6:       return $urandom_range(0, 131071) - 65536;
            default: return $urandom;
        endcase
    endfunction

    // one operand beat: optional idle gap, then hold valid until ready is seen
    task automatic send_operands(input func_t fn, input logic signed [31:0] a,
                                 input logic signed [31:0] b);
        int gap;
        gap = no_idle ? 0 : idle_cycles();
        @(negedge clk);
        if (gap > 0)
        begin
            operands_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        operands_bus.valid     <= 1'b1;
        operands_bus.func      <= fn;
        operands_bus.operand_a <= a;
        operands_bus.operand_b <= b;
        @(posedge clk);
        while (!operands_bus.ready)
            @(posedge clk);
        beats_in++;
    endtask

    // result side: random back-pressure, one long hold-off, none in the burst window
    initial
    begin
        int stall;
        results_bus.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = idle_cycles();
            if (!long_hold_done && beats_in >= HOLD_AT)
            begin
                // sender keeps offering; the chain fills and operand ready drops
                results_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold_done = 1'b1;
            end
            else if (!no_idle && stall > 0)
            begin
                results_bus.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            else
            begin
                results_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        operands_bus.valid     = 1'b0;
        operands_bus.func      = FN_ADD;
        operands_bus.operand_a = '0;
        operands_bus.operand_b = '0;
        rst_n                  = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: wrap corners and every operation
        send_operands(FN_ADD,     32'sh7fff_ffff, 32'sd1);
        send_operands(FN_SUB,     32'sh8000_0000, 32'sd1);
        send_operands(FN_MUL,     32'sh8000_0000, 32'sh8000_0000);
        send_operands(FN_MUL,     32'sh7fff_ffff, 32'sh7fff_ffff);
        // negative product rounds toward minus infinity on the shift
        send_operands(FN_MUL,     -32'sd3,        32'sd5);
        send_operands(FN_DIV,     32'sd1234,      32'sd0);
        send_operands(FN_DIV,     32'sh8000_0000, -32'sd1);
        // quotient truncates toward zero
        send_operands(FN_DIV,     -32'sd7,        32'sd512);
        send_operands(FN_DIV,     32'sh7fff_ffff, 32'sd1);
        send_operands(FN_MAX,     -32'sd5,        -32'sd5);
        send_operands(FN_MAX,     32'sh8000_0000, 32'sh7fff_ffff);
        send_operands(FN_MIN,     32'sh8000_0000, 32'sh7fff_ffff);
        send_operands(FN_GT,      32'sh7fff_ffff, 32'sh8000_0000);
        send_operands(FN_LT,      32'sh7fff_ffff, 32'sh8000_0000);
        send_operands(FN_GE,      32'sd42,        32'sd42);
        send_operands(FN_LE,      32'sd42,        32'sd42);
        send_operands(FN_EQ,      -32'sd1,        -32'sd1);
        send_operands(FN_NE,      -32'sd1,        -32'sd1);
        send_operands(FN_INC,     32'sh7fff_ffff, 32'shdead_beef);
        send_operands(FN_DEC,     32'sh8000_0000, 32'sh1234_5678);
        send_operands(FN_TOINT,   -32'sd1,        32'sd0);
        send_operands(FN_TOINT,   -32'sd257,      32'sd0);
        send_operands(FN_FROMINT, 32'sh0123_4567, 32'sd0);
        send_operands(FN_FROMINT, 32'sh8000_0000, -32'sd1);

        // random: all opcodes, operand mix biased to corners
        for (int i = 0; i < N_RANDOM; i++)
        begin
            no_idle = (i >= BURST_FIRST) && (i <= BURST_LAST);
            send_operands(func_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
        end
        no_idle = 1'b0;

        @(negedge clk);
        operands_bus.valid <= 1'b0;

        // drain, then give the chain time to show any stray beat
        while (n_waiting != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        if (fail_count == 0)
            $display("PASS fixed_point_alu");
        else
            $display("FAIL fixed_point_alu");
        $finish;
    end

endmodule

/* files.f */
src/fpa_pkg.sv
src/fpa_if.sv
src/fpa_front.sv
src/fpa_div_cell.sv
src/fpa_back.sv
src/fixed_point_alu.sv
tb/fpa_result_checker.sv
tb/tb_top.sv
